### rtl/core/thick_line_hexagon_expander_unit_assert.svh
`ifndef THICK_LINE_HEXAGON_EXPANDER_UNIT_ASSERT_SVH
`define THICK_LINE_HEXAGON_EXPANDER_UNIT_ASSERT_SVH
// clocked assertion, disabled while the active-low reset is asserted
`define TLHE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`endif

### rtl/core/tlhe_pkg.sv
package tlhe_pkg;
    // register indexes
    localparam logic [2:0] REG_XROW = 3'd0;
    localparam logic [2:0] REG_YROW = 3'd1;
    localparam logic [2:0] REG_ZROW = 3'd2;
    localparam logic [2:0] REG_OFFXY = 3'd3;
    localparam logic [2:0] REG_OFFZW = 3'd4;
    localparam logic [2:0] REG_HWF = 3'd5;
    localparam logic [2:0] REG_HHF = 3'd6;

    // corner codes
    typedef enum logic [1:0] {
        C_TL = 2'd0,
        C_TR = 2'd1,
        C_BL = 2'd2,
        C_BR = 2'd3
    } t_corner;

    // per endpoint transformed data
    typedef struct packed {
        logic signed [31:0] lft;
        logic signed [31:0] rgt;
        logic signed [31:0] top;
        logic signed [31:0] bot;
        logic signed [31:0] cz;
        logic signed [31:0] cw;
        logic [15:0]        tu;
        logic [15:0]        tv;
        logic [31:0]        col;
    } t_endpt;

    // configuration bundle
    typedef struct packed {
        logic [63:0] xrow;
        logic [63:0] yrow;
        logic [63:0] zrow;
        logic [63:0] offxy;
        logic [63:0] offzw;
        logic [15:0] hwf;
        logic [15:0] hhf;
    } t_cfg;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > 50'sd2147483647) return 32'sh7fffffff;
        if (v < -50'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // corner for vertex i under case sel (A*2+B)
    function automatic t_corner order_lut(input logic [1:0] sel, input logic [2:0] i);
        t_corner c0, c1, c2, c4;
        unique case (sel)
            2'd0: begin c0 = C_TL; c1 = C_TR; c2 = C_BR; c4 = C_BL; end
            2'd1: begin c0 = C_BL; c1 = C_TL; c2 = C_TR; c4 = C_BR; end
            2'd2: begin c0 = C_TR; c1 = C_BR; c2 = C_BL; c4 = C_TL; end
            default: begin c0 = C_BR; c1 = C_BL; c2 = C_TL; c4 = C_TR; end
        endcase
        unique case (i)
            3'd0, 3'd5: return c0;
            3'd1: return c1;
            3'd4: return c4;
            default: return c2;
        endcase
    endfunction
endpackage

### rtl/core/tlhe_xform.sv
// one endpoint through transform, width and saturation; 4 register stages
module tlhe_xform (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  tlhe_pkg::t_cfg       i_cfg,
    input  logic signed [31:0]   i_x,
    input  logic signed [31:0]   i_y,
    input  logic signed [31:0]   i_z,
    input  logic [15:0]          i_u,
    input  logic [15:0]          i_v,
    input  logic [31:0]          i_col,
    output tlhe_pkg::t_endpt     o_ep
);
    import tlhe_pkg::*;

    // stage 1: twelve products
    logic signed [47:0] r_p [4][3];
    logic [15:0] r_u1, r_v1, r_u2, r_v2, r_u3, r_v3;
    logic [31:0] r_c1, r_c2, r_c3;
    logic signed [31:0] r_cx, r_cy, r_cz, r_cw, r_cx3, r_cy3, r_cz3, r_cw3;
    logic signed [48:0] r_hw, r_hh;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_p[k][0] <= i_x * $signed(i_cfg.xrow[16*k +: 16]);
                r_p[k][1] <= i_y * $signed(i_cfg.yrow[16*k +: 16]);
                r_p[k][2] <= i_z * $signed(i_cfg.zrow[16*k +: 16]);
            end
            r_u1 <= i_u; r_v1 <= i_v; r_c1 <= i_col;
        end
    end

    // stage 2: sum, round, saturate
    logic signed [31:0] w_off [4];
    assign w_off[0] = $signed(i_cfg.offxy[31:0]);
    assign w_off[1] = $signed(i_cfg.offxy[63:32]);
    assign w_off[2] = $signed(i_cfg.offzw[31:0]);
    assign w_off[3] = $signed(i_cfg.offzw[63:32]);
    logic signed [49:0] w_acc [4];
    always_comb begin
        for (int k = 0; k < 4; k++)
            w_acc[k] = 50'(r_p[k][0]) + 50'(r_p[k][1]) + 50'(r_p[k][2])
                     + ($signed(50'(w_off[k])) <<< 12) + 50'sd2048;
    end
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx <= sat32(w_acc[0] >>> 12);
            r_cy <= sat32(w_acc[1] >>> 12);
            r_cz <= sat32(w_acc[2] >>> 12);
            r_cw <= sat32(w_acc[3] >>> 12);
            r_u2 <= r_u1; r_v2 <= r_v1; r_c2 <= r_c1;
        end
    end

    // stage 3: half extents
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hw <= ($signed({1'b0, i_cfg.hwf}) * r_cw + 49'sd32768) >>> 16;
            r_hh <= ($signed({1'b0, i_cfg.hhf}) * r_cw + 49'sd32768) >>> 16;
            r_cx3 <= r_cx; r_cy3 <= r_cy; r_cz3 <= r_cz; r_cw3 <= r_cw;
            r_u3 <= r_u2; r_v3 <= r_v2; r_c3 <= r_c2;
        end
    end

    // stage 4: edges
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_ep.lft <= sat32(50'(r_cx3) - 50'(r_hw));
            o_ep.rgt <= sat32(50'(r_cx3) + 50'(r_hw));
            o_ep.top <= sat32(50'(r_cy3) + 50'(r_hh));
            o_ep.bot <= sat32(50'(r_cy3) - 50'(r_hh));
            o_ep.cz <= r_cz3; o_ep.cw <= r_cw3;
            o_ep.tu <= r_u3; o_ep.tv <= r_v3; o_ep.col <= r_c3;
        end
    end
endmodule

### rtl/core/tlhe_emit.sv
// order tests then six-vertex sequencer
module tlhe_emit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  tlhe_pkg::t_endpt  i_e0,
    input  tlhe_pkg::t_endpt  i_e1,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [31:0]       o_x,
    output logic [31:0]       o_y,
    output logic [31:0]       o_z,
    output logic [31:0]       o_w,
    output logic [15:0]       o_u,
    output logic [15:0]       o_v,
    output logic [31:0]       o_col,
    output logic              o_last
);
    import tlhe_pkg::*;

    // test stage: cross products
    logic r_tv;
    t_endpt r_e0, r_e1, r_h0, r_h1;
    logic signed [63:0] r_a0, r_a1, r_b0, r_b1;
    logic r_hv;
    logic [1:0] r_sel;
    logic [2:0] r_idx;
    logic w_hfree, w_tadv, w_ofree, w_done;

    assign w_ofree = !o_valid || !i_stall;
    assign w_done  = r_hv && w_ofree && (r_idx == 3'd5);
    assign w_hfree = !r_hv || w_done;
    assign w_tadv  = !r_tv || w_hfree;
    assign o_stall = !w_tadv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tv <= 1'b0;
        else if (w_tadv) r_tv <= i_valid;
        if (w_tadv) begin
            r_e0 <= i_e0; r_e1 <= i_e1;
            r_a0 <= i_e0.top * i_e1.cw; r_a1 <= i_e1.top * i_e0.cw;
            r_b0 <= i_e0.lft * i_e1.cw; r_b1 <= i_e1.lft * i_e0.cw;
        end
    end

    // hold stage and vertex counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv <= 1'b0; r_idx <= '0;
        end else begin
            if (w_hfree) begin
                r_hv <= r_tv; r_idx <= '0;
            end else if (r_hv && w_ofree) r_idx <= r_idx + 3'd1;
        end
        if (w_hfree) begin
            r_h0 <= r_e0; r_h1 <= r_e1;
            r_sel <= {r_a0 < r_a1, r_b0 < r_b1};
        end
    end

    // vertex pick
    t_endpt w_e;
    t_corner w_c;
    assign w_e = (r_idx < 3'd3) ? r_h0 : r_h1;
    assign w_c = order_lut(r_sel, r_idx);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (w_ofree) o_valid <= r_hv;
        if (w_ofree && r_hv) begin
            o_x <= (w_c == C_TL || w_c == C_BL) ? w_e.lft : w_e.rgt;
            o_y <= (w_c == C_TL || w_c == C_TR) ? w_e.top : w_e.bot;
            o_z <= w_e.cz; o_w <= w_e.cw;
            o_u <= w_e.tu; o_v <= w_e.tv; o_col <= w_e.col;
            o_last <= (r_idx == 3'd5);
        end
    end

    `include "thick_line_hexagon_expander_unit_assert.svh"
    `TLHE_ASSERT(a_idx_range, (r_idx <= 3'd5), "vertex index out of range")
    `TLHE_ASSERT(a_idx_idle, (!r_hv |-> r_idx == 3'd0), "index moved while idle")
    `TLHE_ASSERT(a_out_hold, (o_valid && i_stall |=> o_valid && $stable(o_x)), "output lost")
endmodule

### rtl/core/thick_line_hexagon_expander_unit.sv
// Thick line expander: each accepted segment yields six clip-space vertices of a
// hexagon, one per cycle unless the output stalls; sustained segment intake is set by
// the single vertex output port. The first vertex passes the 4-stage transform, the
// order-test stage, the hold stage and the output register.
module thick_line_hexagon_expander_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_start_z,
    input  logic signed [15:0] i_start_u,
    input  logic signed [15:0] i_start_v,
    input  logic [31:0]        i_start_color,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_end_z,
    input  logic signed [15:0] i_end_u,
    input  logic signed [15:0] i_end_v,
    input  logic [31:0]        i_end_color,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_out_x,
    output logic signed [31:0] o_out_y,
    output logic signed [31:0] o_out_z,
    output logic signed [31:0] o_out_w,
    output logic signed [15:0] o_out_u,
    output logic signed [15:0] o_out_v,
    output logic [31:0]        o_out_color,
    output logic               o_last_vertex
);
    import tlhe_pkg::*;

    // configuration registers
    t_cfg r_cfg;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.xrow <= 64'd4096;
            r_cfg.yrow <= 64'h1000_0000;
            r_cfg.zrow <= 64'h1000_0000_0000;
            r_cfg.offxy <= '0;
            r_cfg.offzw <= 64'h1_0000_0000_0000;
            r_cfg.hwf <= '0;
            r_cfg.hhf <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_XROW:  r_cfg.xrow <= i_cfg_data;
                REG_YROW:  r_cfg.yrow <= i_cfg_data;
                REG_ZROW:  r_cfg.zrow <= i_cfg_data;
                REG_OFFXY: r_cfg.offxy <= i_cfg_data;
                REG_OFFZW: r_cfg.offzw <= i_cfg_data;
                REG_HWF:   r_cfg.hwf <= i_cfg_data[15:0];
                REG_HHF:   r_cfg.hhf <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // transform pipeline valid bits
    logic [3:0] r_pv;
    logic w_en, w_dstall;
    assign w_en = !r_pv[3] || !w_dstall;
    assign o_stall = !w_en;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pv <= '0;
        else if (w_en) r_pv <= {r_pv[2:0], i_valid};
    end

    t_endpt w_e0, w_e1;
    tlhe_xform u_x0 (
        .i_clk, .i_en(w_en), .i_cfg(r_cfg),
        .i_x(i_start_x), .i_y(i_start_y), .i_z(i_start_z),
        .i_u(i_start_u), .i_v(i_start_v), .i_col(i_start_color), .o_ep(w_e0)
    );
    tlhe_xform u_x1 (
        .i_clk, .i_en(w_en), .i_cfg(r_cfg),
        .i_x(i_end_x), .i_y(i_end_y), .i_z(i_end_z),
        .i_u(i_end_u), .i_v(i_end_v), .i_col(i_end_color), .o_ep(w_e1)
    );

    tlhe_emit u_emit (
        .i_clk, .i_rst_n, .i_valid(r_pv[3]), .o_stall(w_dstall),
        .i_e0(w_e0), .i_e1(w_e1), .o_valid, .i_stall,
        .o_x(o_out_x), .o_y(o_out_y), .o_z(o_out_z), .o_w(o_out_w),
        .o_u(o_out_u), .o_v(o_out_v), .o_col(o_out_color), .o_last(o_last_vertex)
    );
endmodule

### test/hexagon_vertex_checker.sv
import tlhe_pkg::*;

module hexagon_vertex_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [63:0]        i_cfg_data,
    input  logic               i_valid,
    input  logic               o_stall,
    input  logic signed [31:0] i_start_x,
    input  logic signed [31:0] i_start_y,
    input  logic signed [31:0] i_start_z,
    input  logic signed [15:0] i_start_u,
    input  logic signed [15:0] i_start_v,
    input  logic [31:0]        i_start_color,
    input  logic signed [31:0] i_end_x,
    input  logic signed [31:0] i_end_y,
    input  logic signed [31:0] i_end_z,
    input  logic signed [15:0] i_end_u,
    input  logic signed [15:0] i_end_v,
    input  logic [31:0]        i_end_color,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic signed [31:0] o_out_x,
    input  logic signed [31:0] o_out_y,
    input  logic signed [31:0] o_out_z,
    input  logic signed [31:0] o_out_w,
    input  logic signed [15:0] o_out_u,
    input  logic signed [15:0] o_out_v,
    input  logic [31:0]        o_out_color,
    input  logic               o_last_vertex,
    output int                 n_errors,
    output int                 n_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic signed [31:0] x, y, z, w;
        logic [15:0]        u, v;
        logic [31:0]        color;
        logic               last;
    } vertex_t;

    // corner sequence per case, index A*2+B, first three from the start point
    localparam t_corner HEX_ORDER [4][6] = '{
        '{C_TL, C_TR, C_BR, C_BR, C_BL, C_TL},
        '{C_BL, C_TL, C_TR, C_TR, C_BR, C_BL},
        '{C_TR, C_BR, C_BL, C_BL, C_TL, C_TR},
        '{C_BR, C_BL, C_TL, C_TL, C_TR, C_BR}
    };

    t_cfg    cfg;
    vertex_t vertex_q[$];

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // one row of the matrix, rounded from Q.28 back to Q16.16
    function automatic longint clip_lane(longint x, longint y, longint z, int k,
                                         longint off);
        longint acc;
        acc = x * longint'($signed(cfg.xrow[16*k +: 16]))
            + y * longint'($signed(cfg.yrow[16*k +: 16]))
            + z * longint'($signed(cfg.zrow[16*k +: 16])) + off * 4096;
        return clamp32((acc + 2048) >>> 12);
    endfunction

    function automatic t_endpt transform_endpoint(longint x, longint y, longint z,
                                                  logic [15:0] u, logic [15:0] v,
                                                  logic [31:0] color);
        longint cx, cy, cw, hw, hh;
        t_endpt e;
        cx = clip_lane(x, y, z, 0, longint'($signed(cfg.offxy[31:0])));
        cy = clip_lane(x, y, z, 1, longint'($signed(cfg.offxy[63:32])));
        cw = clip_lane(x, y, z, 3, longint'($signed(cfg.offzw[63:32])));
        e.cz = clip_lane(x, y, z, 2, longint'($signed(cfg.offzw[31:0])));
        e.cw = cw;
        // negative W gives negative half sizes, used as they are
        hw = (longint'(cfg.hwf) * cw + 32768) >>> 16;
        hh = (longint'(cfg.hhf) * cw + 32768) >>> 16;
        e.lft = clamp32(cx - hw);
        e.rgt = clamp32(cx + hw);
        e.top = clamp32(cy + hh);
        e.bot = clamp32(cy - hh);
        e.tu = u;
        e.tv = v;
        e.col = color;
        return e;
    endfunction

    // six hexagon corners of the segment now on the input
    function automatic void expand_segment();
        t_endpt  ep[2];
        t_endpt  e;
        t_corner c;
        logic    a, b;
        vertex_t vx;
        ep[0] = transform_endpoint(i_start_x, i_start_y, i_start_z, i_start_u,
                                   i_start_v, i_start_color);
        ep[1] = transform_endpoint(i_end_x, i_end_y, i_end_z, i_end_u,
                                   i_end_v, i_end_color);
        a = longint'($signed(ep[0].top)) * longint'($signed(ep[1].cw))
          < longint'($signed(ep[1].top)) * longint'($signed(ep[0].cw));
        b = longint'($signed(ep[0].lft)) * longint'($signed(ep[1].cw))
          < longint'($signed(ep[1].lft)) * longint'($signed(ep[0].cw));
        for (int i = 0; i < 6; i++) begin
            e = ep[i < 3 ? 0 : 1];
            c = HEX_ORDER[{a, b}][i];
            vx.x = (c == C_TL || c == C_BL) ? e.lft : e.rgt;
            vx.y = (c == C_TL || c == C_TR) ? e.top : e.bot;
            vx.z = e.cz;
            vx.w = e.cw;
            vx.u = e.tu;
            vx.v = e.tv;
            vx.color = e.col;
            vx.last = (i == 5);
            vertex_q.push_back(vx);
        end
    endfunction

    function automatic int check_field(string name, longint exp_v, longint act_v);
        if (exp_v == act_v) return 0;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
        return 1;
    endfunction

    // register mirror, transfer tracking and comparison
    always @(posedge i_clk) begin
        vertex_t ev;
        int      bad;
        if (!i_rst_n) begin
            cfg <= '{xrow: 64'd4096, yrow: 64'd268435456, zrow: 64'd17592186044416,
                     offxy: 64'd0, offzw: 64'd281474976710656, hwf: 16'd0, hhf: 16'd0};
            vertex_q.delete();
            n_errors <= 0;
            n_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_XROW:  cfg.xrow <= i_cfg_data;
                    REG_YROW:  cfg.yrow <= i_cfg_data;
                    REG_ZROW:  cfg.zrow <= i_cfg_data;
                    REG_OFFXY: cfg.offxy <= i_cfg_data;
                    REG_OFFZW: cfg.offzw <= i_cfg_data;
                    REG_HWF:   cfg.hwf <= i_cfg_data[15:0];
                    REG_HHF:   cfg.hhf <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_valid && !o_stall) expand_segment();
            if (o_valid && !i_stall) begin
                if (vertex_q.size() == 0) begin
                    $display("%0t: vertex transfer with none expected, actual x %0h",
                             $time, o_out_x);
                    n_errors <= n_errors + 1;
                end else begin
                    ev = vertex_q.pop_front();
                    bad = check_field("x", ev.x, o_out_x)
                        + check_field("y", ev.y, o_out_y)
                        + check_field("z", ev.z, o_out_z)
                        + check_field("w", ev.w, o_out_w)
                        + check_field("u", ev.u, o_out_u[15:0])
                        + check_field("v", ev.v, o_out_v[15:0])
                        + check_field("color", ev.color, o_out_color)
                        + check_field("last", ev.last, o_last_vertex);
                    if (bad != 0) n_errors <= n_errors + 1;
                end
            end
            n_pending <= vertex_q.size();
        end
    end
endmodule

### test/tb.sv
import tlhe_pkg::*;

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;
    localparam logic [2:0] REG_NONE = 3'd7;

    typedef struct {
        logic signed [31:0] sx, sy, sz, ex, ey, ez;
        logic [15:0]        su, sv, eu, ev;
        logic [31:0]        sc, ec;
    } segment_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [63:0]        i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_start_x = '0, i_start_y = '0, i_start_z = '0;
    logic signed [15:0] i_start_u = '0, i_start_v = '0;
    logic [31:0]        i_start_color = '0;
    logic signed [31:0] i_end_x = '0, i_end_y = '0, i_end_z = '0;
    logic signed [15:0] i_end_u = '0, i_end_v = '0;
    logic [31:0]        i_end_color = '0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic signed [31:0] o_out_x, o_out_y, o_out_z, o_out_w;
    logic signed [15:0] o_out_u, o_out_v;
    logic [31:0]        o_out_color;
    logic               o_last_vertex;
    int                 n_errors, n_pending;

    int tx_max = 14;
    int rx_max = 14;
    bit hold_req = 0;
    int n_segments = 0;
    int n_settings = 1;
    int idle_cycles = 0;

    thick_line_hexagon_expander_unit dut (.*);
    hexagon_vertex_checker chk (.*);

    always #1 i_clk = ~i_clk;

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles == IDLE_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    // result side stalls, with one long hold when asked
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = $urandom_range(0, rx_max);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (150) @(posedge i_clk);
                hold_req = 0;
            end else if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'hffffffff;
            4, 5: return $urandom;
            default: return $urandom_range(0, 32'h00800000) - 32'h00400000;
        endcase
    endfunction

    function automatic logic [15:0] pick_tex();
        case ($urandom_range(0, 4))
            0: return 16'h7fff;
            1: return 16'h8000;
            default: return $urandom;
        endcase
    endfunction

    function automatic segment_t random_segment();
        segment_t s;
        s.sx = pick_coord(); s.sy = pick_coord(); s.sz = pick_coord();
        s.ex = pick_coord(); s.ey = pick_coord(); s.ez = pick_coord();
        s.su = pick_tex(); s.sv = pick_tex(); s.eu = pick_tex(); s.ev = pick_tex();
        s.sc = $urandom; s.ec = $urandom;
        return s;
    endfunction

    function automatic segment_t line_segment(logic [31:0] x0, logic [31:0] y0,
                                              logic [31:0] x1, logic [31:0] y1);
        segment_t s;
        s = random_segment();
        s.sx = x0; s.sy = y0; s.ex = x1; s.ey = y1;
        return s;
    endfunction

    // valid stays high from one transfer to the next when there is no gap
    task automatic send_segment(segment_t s);
        int gap;
        gap = $urandom_range(0, tx_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start_x <= s.sx; i_start_y <= s.sy; i_start_z <= s.sz;
        i_start_u <= s.su; i_start_v <= s.sv; i_start_color <= s.sc;
        i_end_x <= s.ex; i_end_y <= s.ey; i_end_z <= s.ez;
        i_end_u <= s.eu; i_end_v <= s.ev; i_end_color <= s.ec;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        n_segments++;
    endtask

    // sender pause until every vertex is out, then the pipeline drains
    task automatic drain();
        i_valid <= 1'b0;
        while (n_pending != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_setting(logic [63:0] xr, logic [63:0] yr, logic [63:0] zr,
                                logic [63:0] oxy, logic [63:0] ozw,
                                logic [63:0] hwf, logic [63:0] hhf);
        drain();
        write_reg(REG_XROW, xr);
        write_reg(REG_YROW, yr);
        write_reg(REG_ZROW, zr);
        write_reg(REG_OFFXY, oxy);
        write_reg(REG_OFFZW, ozw);
        write_reg(REG_HWF, hwf);
        write_reg(REG_HHF, hhf);
        // an index past the list is ignored
        write_reg(REG_NONE, {$urandom, $urandom});
        n_settings++;
    endtask

    task automatic run_random(int count);
        repeat (count) send_segment(random_segment());
    endtask

    // every vertex order, field extremes
    task automatic run_directed();
        segment_t s;
        send_segment(line_segment(0, 0, 32'h10000, 32'h10000));
        send_segment(line_segment(0, 0, 32'h10000, 32'hffff0000));
        send_segment(line_segment(0, 0, 32'hffff0000, 32'h10000));
        send_segment(line_segment(0, 0, 32'hffff0000, 32'hffff0000));
        send_segment(line_segment(32'h30000, 32'h20000, 32'h30000, 32'h20000));
        s = line_segment(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000);
        s.sz = 32'h7fffffff; s.ez = 32'h80000000;
        s.su = 16'h7fff; s.sv = 16'h7fff; s.eu = 16'h8000; s.ev = 16'h8000;
        s.sc = 32'hffffffff; s.ec = 32'h0;
        send_segment(s);
        s = line_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        s.sz = 32'h80000000; s.ez = 32'h7fffffff;
        s.su = 16'h8000; s.sv = 16'h0; s.eu = 16'h0; s.ev = 16'h7fff;
        s.sc = 32'h0; s.ec = 32'hffffffff;
        send_segment(s);
        s = line_segment(0, 0, 0, 0);
        s.sz = 0; s.ez = 0;
        send_segment(s);
        send_segment(line_segment(32'hffffffff, 32'h1, 32'h1, 32'hffffffff));
        send_segment(line_segment(32'h7fffffff, 32'h80000000, 32'h80000000,
                                  32'h7fffffff));
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: identity, W of one, zero width
        run_directed();

        // wide line, then negative W
        load_setting(64'd4096, 64'd268435456, 64'd17592186044416, 64'd0,
                     64'h0001_0000_0000_0000, {$urandom, 16'h1000},
                     {$urandom, 16'h2000});
        run_directed();
        load_setting(64'd4096, 64'd268435456, 64'd17592186044416, 64'd0,
                     64'hffff_0000_0000_0000, 64'h4000, 64'h6000);
        run_directed();
        run_random(30);

        // random matrices
        load_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom});
        run_random(50);

        // all ones everywhere
        load_setting('1, '1, '1, '1, '1, '1, '1);
        run_random(40);

        // largest positive lanes, offsets at both extremes
        load_setting(64'h7fff_7fff_7fff_7fff, 64'h7fff_7fff_7fff_7fff,
                     64'h7fff_7fff_7fff_7fff, 64'h8000_0000_7fff_ffff,
                     64'h7fff_ffff_8000_0000, 64'hffff, 64'hffff);
        run_random(40);

        // most negative lanes
        load_setting(64'h8000_8000_8000_8000, 64'h8000_8000_8000_8000,
                     64'h8000_8000_8000_8000, 64'h7fff_ffff_8000_0000,
                     64'h8000_0000_7fff_ffff, 64'h0, 64'hffff);
        run_random(30);

        // all zero
        load_setting('0, '0, '0, '0, '0, '0, '0);
        run_random(20);

        // random setting with a long output hold while segments keep coming
        load_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                     {$urandom, $urandom});
        run_random(20);
        hold_req = 1;
        tx_max = 0;
        run_random(30);
        tx_max = 14;
        drain();
        run_random(30);

        // back to back on both sides
        load_setting(64'h0000_0010_0200_1000, 64'h0000_0020_1000_0100,
                     64'h1000_0800_0010_0010, {$urandom, $urandom},
                     64'h0001_0000_0000_0000, 64'h0800, 64'h0800);
        tx_max = 0;
        rx_max = 0;
        run_random(50);
        tx_max = 14;
        rx_max = 14;
        run_random(20);

        i_valid <= 1'b0;
        while (n_pending != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("tb: %0d segments, %0d vertices, %0d register settings", n_segments,
                 6 * n_segments, n_settings);
        $display("tb: covered all four vertex orders, negative W, saturation, stalls");
        if (n_errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
